// ----- src/video_line_data_slicer_unit_assert.svh -----
// Assertion macros for the video line data slicer.
`ifndef VIDEO_LINE_DATA_SLICER_UNIT_ASSERT_SVH
`define VIDEO_LINE_DATA_SLICER_UNIT_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define VLDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define VLDS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ----- src/vlds_pkg.sv -----
// Shared types and constants of the video line data slicer.
`default_nettype none

package vlds_pkg;

  // Sync pattern, first sliced bit in the MSB
  localparam logic [15:0] SYNC_WORD = 16'hAAAB;

  // Header bytes
  localparam logic [7:0] HDR_BYTE0 = 8'hEC;
  localparam logic [7:0] HDR_BYTE1 = 8'h98;
  localparam logic [7:0] HDR_BYTE3 = 8'hAA;

  // Entry tag in the middle byte
  localparam logic [7:0] ENTRY_TAG_MASK = 8'hC0;
  localparam logic [7:0] ENTRY_TAG      = 8'h80;

  // Record kinds
  localparam logic REC_ENTRY   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  // Line status codes
  localparam logic [1:0] LS_OK       = 2'd0;
  localparam logic [1:0] LS_MISMATCH = 2'd1;
  localparam logic [1:0] LS_NO_SYNC  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_SYNC_LIMIT = 1'b1;

  // Register reset values
  localparam logic [7:0] THRESHOLD_RST  = 8'h40;
  localparam logic [7:0] SYNC_LIMIT_RST = 8'd31;

  // Result queue geometry
  localparam int RES_FIFO_DEPTH = 4;
  localparam int PTR_W          = $clog2(RES_FIFO_DEPTH);
  localparam int FILL_W         = $clog2(RES_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] pixel;
    logic       end_of_line;
  } vlds_in_t;

  typedef struct packed {
    logic       record_kind;
    logic [7:0] entry_index;
    logic [1:0] source_type;
    logic [4:0] page_slot;
    logic [4:0] page_number;
    logic [1:0] line_status;
    logic [7:0] header_count;
    logic [6:0] valid_entries;
    logic       last_of_line;
  } vlds_out_t;

  // Results of one processed pixel: an entry first, then a summary
  typedef struct packed {
    logic      entry_vld;
    logic      summary_vld;
    vlds_out_t entry;
    vlds_out_t summary;
  } vlds_res_t;

endpackage

`default_nettype wire

// ----- src/vlds_slicer.sv -----
// Slicing, sync hunt, byte packing and entry decode, one pixel per cycle with step_i.
`default_nettype none

module vlds_slicer
  import vlds_pkg::*;
#(
  parameter int LINE_PIXELS       = 1920,
  parameter int MAX_ENTRIES       = 64,
  parameter int PACKED_BYTE_LIMIT = 240
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  vlds_in_t       item_i,
  input  wire logic [7:0] threshold_i,
  input  wire logic [7:0] sync_limit_i,
  output vlds_res_t      res_o
);

  localparam int POS_W    = $clog2(LINE_PIXELS);
  localparam int BPOS_W   = $clog2(PACKED_BYTE_LIMIT + 1);
  localparam int CMP_W    = (POS_W > 8) ? POS_W : 8;
  localparam int EMIT_CAP = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;
  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(LINE_PIXELS - 1);
  localparam logic [POS_W-1:0]  SYNC_SPAN  = POS_W'(15);
  localparam logic [BPOS_W-1:0] HDR_BYTES  = BPOS_W'(4);
  localparam logic [BPOS_W-1:0] BYTE_LIMIT = BPOS_W'(PACKED_BYTE_LIMIT);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       window_q, window_d;
  logic              sync_q, sync_d;
  logic [2:0]        bitcnt_q, bitcnt_d;
  logic [7:0]        shift_q, shift_d;
  logic [BPOS_W-1:0] bpos_q, bpos_d;
  logic [7:0]        hdr_q [4];
  logic [7:0]        hdr_d [4];
  logic [7:0]        ent_q [2];
  logic [7:0]        ent_d [2];
  logic [1:0]        phase_q, phase_d;
  logic [7:0]        seen_q, seen_d;
  logic [6:0]        emitted_q, emitted_d;

  logic      bit_val;
  logic      take;
  logic      hdr_ok_q;
  logic      hdr_ok_d;
  logic      end_line;
  vlds_res_t res;

  assign bit_val  = (item_i.pixel >= threshold_i);
  assign hdr_ok_q = (bpos_q >= HDR_BYTES) && (hdr_q[0] == HDR_BYTE0) &&
                    (hdr_q[1] == HDR_BYTE1) && (hdr_q[3] == HDR_BYTE3);
  assign end_line = item_i.end_of_line || (pos_q >= LAST_POS);

  // Next line state and results for the pixel in the input register
  always_comb begin
    pos_d     = pos_q;
    window_d  = window_q;
    sync_d    = sync_q;
    bitcnt_d  = bitcnt_q;
    shift_d   = shift_q;
    bpos_d    = bpos_q;
    hdr_d     = hdr_q;
    ent_d     = ent_q;
    phase_d   = phase_q;
    seen_d    = seen_q;
    emitted_d = emitted_q;
    take      = 1'b0;
    res       = '0;

    // Hunt for sync, or shift the bit into the byte after sync
    if (!sync_q) begin
      window_d = {window_q[14:0], bit_val};
      if ((window_d == SYNC_WORD) && (pos_q >= SYNC_SPAN) &&
          (CMP_W'(pos_q - SYNC_SPAN) <= CMP_W'(sync_limit_i))) begin
        sync_d = 1'b1;
      end
    end else begin
      shift_d  = {bit_val, shift_q[7:1]};
      bitcnt_d = bitcnt_q + 3'd1;
      take     = (bitcnt_d == 3'd0);
    end

    // Store a finished byte as header, entry part, or decode an entry
    if (take && (bpos_q < BYTE_LIMIT)) begin
      bpos_d = bpos_q + BPOS_W'(1);
      if (bpos_q < HDR_BYTES) begin
        hdr_d[bpos_q[1:0]] = shift_d;
      end else if (phase_q != 2'd2) begin
        ent_d[phase_q[0]] = shift_d;
        phase_d           = phase_q + 2'd1;
      end else begin
        phase_d = 2'd0;
        if (hdr_ok_q && (seen_q < hdr_q[2]) &&
            ((ent_q[1] & ENTRY_TAG_MASK) == ENTRY_TAG) &&
            (emitted_q < 7'(EMIT_CAP))) begin
          res.entry_vld         = 1'b1;
          res.entry.record_kind = REC_ENTRY;
          res.entry.entry_index = ent_q[0];
          res.entry.source_type = shift_d[7:6];
          res.entry.page_slot   = ent_q[1][4:0];
          res.entry.page_number = shift_d[4:0];
          emitted_d             = emitted_q + 7'd1;
        end
        if (seen_q != 8'hFF) begin
          seen_d = seen_q + 8'd1;
        end
      end
    end

    hdr_ok_d = (bpos_d >= HDR_BYTES) && (hdr_d[0] == HDR_BYTE0) &&
               (hdr_d[1] == HDR_BYTE1) && (hdr_d[3] == HDR_BYTE3);

    // Emit the summary and clear the line, or advance the position
    if (end_line) begin
      res.summary_vld           = 1'b1;
      res.summary.record_kind   = REC_SUMMARY;
      res.summary.line_status   = !sync_d ? LS_NO_SYNC : (hdr_ok_d ? LS_OK : LS_MISMATCH);
      res.summary.header_count  = (sync_d && hdr_ok_d) ? hdr_d[2] : 8'd0;
      res.summary.valid_entries = emitted_d;
      res.summary.last_of_line  = 1'b1;
      pos_d     = '0;
      window_d  = '0;
      sync_d    = 1'b0;
      bitcnt_d  = '0;
      shift_d   = '0;
      bpos_d    = '0;
      hdr_d     = '{default: '0};
      ent_d     = '{default: '0};
      phase_d   = '0;
      seen_d    = '0;
      emitted_d = '0;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  // Hold line state, advance on each processed pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      window_q  <= '0;
      sync_q    <= 1'b0;
      bitcnt_q  <= '0;
      shift_q   <= '0;
      bpos_q    <= '0;
      hdr_q     <= '{default: '0};
      ent_q     <= '{default: '0};
      phase_q   <= '0;
      seen_q    <= '0;
      emitted_q <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      window_q  <= window_d;
      sync_q    <= sync_d;
      bitcnt_q  <= bitcnt_d;
      shift_q   <= shift_d;
      bpos_q    <= bpos_d;
      hdr_q     <= hdr_d;
      ent_q     <= ent_d;
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      emitted_q <= emitted_d;
    end
  end

  // Results count only on a processed pixel
  always_comb begin
    res_o             = res;
    res_o.entry_vld   = res.entry_vld && step_i;
    res_o.summary_vld = res.summary_vld && step_i;
  end

endmodule

`default_nettype wire

// ----- src/vlds_result_fifo.sv -----
// Result queue: takes up to two results per cycle, hands out one per request.
`default_nettype none

module vlds_result_fifo
  import vlds_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  vlds_res_t         push_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output vlds_out_t         out_data_o,
  output logic [FILL_W-1:0] fill_o
);

  vlds_out_t         mem_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              push0, push1, pop;
  vlds_out_t         data0;
  logic [1:0]        n_push;

  // Entry goes first when both results come from one pixel
  assign push0  = push_i.entry_vld || push_i.summary_vld;
  assign push1  = push_i.entry_vld && push_i.summary_vld;
  assign data0  = push_i.entry_vld ? push_i.entry : push_i.summary;
  assign n_push = {1'b0, push0} + {1'b0, push1};
  assign pop    = out_valid_o && out_ready_i;
  assign fill_d = fill_q + FILL_W'(n_push) - FILL_W'(pop);

  assign out_valid_o = (fill_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign fill_o      = fill_q;

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push0) begin
      mem_q[wr_ptr_q] <= data0;
    end
    if (push1) begin
      mem_q[wr_ptr_q + PTR_W'(1)] <= push_i.summary;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/video_line_data_slicer_unit.sv -----
// An accepted pixel request waits in the input register and is processed when
// the queue has room, which queues its results; the first can then leave.
// Throughput: one pixel per cycle; input stalls while the result queue
// holds more than two results, and drains one result a cycle on out_ready_i.
// Reset clears line state, the queue and restores threshold 64, sync limit 31.
// Top level of the video line data slicer.
`default_nettype none

module video_line_data_slicer_unit
  import vlds_pkg::*;
#(
  parameter int LINE_PIXELS       = 1920,
  parameter int MAX_ENTRIES       = 64,
  parameter int PACKED_BYTE_LIMIT = 240
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  vlds_in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output vlds_out_t       out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  localparam int EMIT_CAP = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;

  logic [7:0]        threshold_q;
  logic [7:0]        sync_limit_q;
  logic              s1_valid_q;
  vlds_in_t          s1_item_q;
  logic              fire;
  logic              room;
  logic [FILL_W-1:0] fifo_fill;
  vlds_res_t         core_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RST;
      sync_limit_q <= SYNC_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:  threshold_q  <= cfg_wdata_i;
        CFG_SYNC_LIMIT: sync_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Process the held request when the queue can take two results
  assign room       = (fifo_fill <= FILL_W'(RES_FIFO_DEPTH - 2));
  assign fire       = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
  end

  vlds_slicer #(
    .LINE_PIXELS      (LINE_PIXELS),
    .MAX_ENTRIES      (MAX_ENTRIES),
    .PACKED_BYTE_LIMIT(PACKED_BYTE_LIMIT)
  ) u_slicer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .item_i      (s1_item_q),
    .threshold_i (threshold_q),
    .sync_limit_i(sync_limit_q),
    .res_o       (core_res)
  );

  vlds_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (core_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .fill_o     (fifo_fill)
  );

`include "video_line_data_slicer_unit_assert.svh"

  `VLDS_ASSERT(a_fill_bound, fifo_fill <= FILL_W'(RES_FIFO_DEPTH), "result queue overfilled")
  `VLDS_ASSERT_IMPL(a_entry_cap, fire && core_res.summary_vld, core_res.summary.valid_entries <= 7'(EMIT_CAP), "entry cap exceeded")
  `VLDS_ASSERT_IMPL(a_bad_hdr_count, fire && core_res.summary_vld && core_res.summary.line_status != LS_OK, core_res.summary.header_count == 8'd0, "count on bad header")

endmodule

`default_nettype wire
